/* rtl/clr_pkg.sv */
`default_nettype none
package clr_pkg;

	// Fixed field widths of the pixel stream and the configuration registers.
	localparam int COLOR_BITS = 16;
	localparam int ADDR_BITS  = 20;
	localparam int DIM_BITS   = 11;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	// Screen size after reset.
	localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 11'd240;
	localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 11'd160;

	// Command codes.
	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} opcode_t;

	// Register index, taken from address bit 2.
	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

endpackage
`default_nettype wire

/* rtl/clr_ifs.sv */
`default_nettype none
// Command channel: start a line or step it by one pixel.
interface clr_cmd_if #(
	parameter int COORD_BITS = 12
);
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [COORD_BITS-1:0]         x_start;
	logic signed [COORD_BITS-1:0]         y_start;
	logic signed [COORD_BITS-1:0]         x_end;
	logic signed [COORD_BITS-1:0]         y_end;
	logic [clr_pkg::COLOR_BITS-1:0]       line_color;

	modport source (
		output valid, opcode, x_start, y_start, x_end, y_end, line_color,
		input  ready
	);
	modport sink (
		input  valid, opcode, x_start, y_start, x_end, y_end, line_color,
		output ready
	);
endinterface

// Pixel channel: one beat per step command.
interface clr_pixel_if #(
	parameter int COORD_BITS = 12
);
	logic                                 valid;
	logic                                 ready;
	logic signed [COORD_BITS-1:0]         pixel_x;
	logic signed [COORD_BITS-1:0]         pixel_y;
	logic [clr_pkg::ADDR_BITS-1:0]        pixel_address;
	logic [clr_pkg::COLOR_BITS-1:0]       pixel_color;
	logic                                 write_enable;
	logic                                 last_pixel;
	logic                                 line_idle;

	modport source (
		output valid, pixel_x, pixel_y, pixel_address, pixel_color,
		       write_enable, last_pixel, line_idle,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_address, pixel_color,
		       write_enable, last_pixel, line_idle,
		output ready
	);
endinterface
`default_nettype wire

/* rtl/clipped_line_rasterizer.sv */
// A step beat gives its pixel beat through the stage-1 and stage-2 registers.
// One command per cycle while the pixel side is not stalled; the Bresenham state
// updates in the accepting cycle and the frame-buffer multiply sits in the second stage.
// A start beat gives no pixel beat.
// Reset (arst_n, asynchronous, active low) clears the line state and the
// pipeline, and sets the screen to 240 by 160.
`default_nettype none
module clipped_line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	clr_cmd_if.sink                               cmd,
	clr_pixel_if.source                           pixel,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire [clr_pkg::APB_ADDR_BITS-1:0]      paddr,
	input  wire [clr_pkg::APB_DATA_BITS-1:0]      pwdata,
	output logic [clr_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);

	localparam int C         = COORD_BITS;
	localparam int D         = C + 1;
	localparam int E         = C + 3;
	localparam int POS_BITS  = C - 1;
	localparam int DIM       = clr_pkg::DIM_BITS;
	localparam int CMP_BITS  = (POS_BITS > DIM ? POS_BITS : DIM);
	localparam int PROD_BITS = POS_BITS + DIM;
	localparam int SUM_BITS  = (PROD_BITS > clr_pkg::ADDR_BITS ? PROD_BITS
		: clr_pkg::ADDR_BITS) + 1;

	// Configuration registers.
	logic [DIM-1:0] width_q;
	logic [DIM-1:0] height_q;
	logic           cfg_write;
	logic           reg_sel;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel   = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clr_pkg::RESET_WIDTH;
			height_q <= clr_pkg::RESET_HEIGHT;
		end else if (cfg_write) begin
			case (reg_sel)
				clr_pkg::REG_WIDTH:  width_q  <= pwdata[DIM-1:0];
				clr_pkg::REG_HEIGHT: height_q <= pwdata[DIM-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			clr_pkg::REG_WIDTH:  prdata = clr_pkg::APB_DATA_BITS'(width_q);
			clr_pkg::REG_HEIGHT: prdata = clr_pkg::APB_DATA_BITS'(height_q);
			default:             prdata = '0;
		endcase
	end

	// Pipeline flow control.
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;
	logic fire;
	logic is_step;

	assign adv_s2    = !valid_s2 || pixel.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;
	assign fire      = cmd.valid && adv_s1;
	assign is_step   = (cmd.opcode == clr_pkg::OP_STEP);

	// Line state.
	logic signed [C-1:0] cur_x_q;
	logic signed [C-1:0] cur_y_q;
	logic signed [C-1:0] tgt_x_q;
	logic signed [C-1:0] tgt_y_q;
	logic signed [D-1:0] delta_x_q;
	logic signed [D-1:0] neg_delta_y_q;
	logic signed [E-1:0] err_q;
	logic                step_x_neg_q;
	logic                step_y_neg_q;
	logic [clr_pkg::COLOR_BITS-1:0] color_q;
	logic                line_active_q;

	// Start: deltas and initial error.
	logic signed [D-1:0] dx_raw;
	logic signed [D-1:0] dy_raw;
	logic signed [D-1:0] dx_abs;
	logic signed [D-1:0] dy_negabs;

	assign dx_raw    = D'(cmd.x_end) - D'(cmd.x_start);
	assign dy_raw    = D'(cmd.y_end) - D'(cmd.y_start);
	assign dx_abs    = dx_raw[D-1] ? -dx_raw : dx_raw;
	assign dy_negabs = dy_raw[D-1] ? dy_raw : -dy_raw;

	// Step: endpoint test and one Bresenham move.
	logic                  at_end;
	logic signed [E:0]     twice;
	logic                  move_x;
	logic                  move_y;
	logic signed [E-1:0]   err_next;

	assign at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign twice    = {err_q, 1'b0};
	assign move_x   = twice >= (E+1)'(neg_delta_y_q);
	assign move_y   = twice <= (E+1)'(delta_x_q);
	assign err_next = err_q + (move_x ? E'(neg_delta_y_q) : E'(0))
		+ (move_y ? E'(delta_x_q) : E'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			tgt_x_q       <= '0;
			tgt_y_q       <= '0;
			delta_x_q     <= '0;
			neg_delta_y_q <= '0;
			err_q         <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			color_q       <= '0;
			line_active_q <= 1'b0;
		end else if (fire) begin
			if (!is_step) begin
				cur_x_q       <= cmd.x_start;
				cur_y_q       <= cmd.y_start;
				tgt_x_q       <= cmd.x_end;
				tgt_y_q       <= cmd.y_end;
				delta_x_q     <= dx_abs;
				neg_delta_y_q <= dy_negabs;
				err_q         <= E'(dx_abs) + E'(dy_negabs);
				step_x_neg_q  <= !(cmd.x_start < cmd.x_end);
				step_y_neg_q  <= !(cmd.y_start < cmd.y_end);
				color_q       <= cmd.line_color;
				line_active_q <= 1'b1;
			end else if (line_active_q) begin
				if (at_end) begin
					line_active_q <= 1'b0;
				end else begin
					err_q <= err_next;
					if (move_x) begin
						cur_x_q <= step_x_neg_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
					end
					if (move_y) begin
						cur_y_q <= step_y_neg_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
					end
				end
			end
		end
	end

	// Clip test on the current pixel.
	logic on_screen;

	assign on_screen = !cur_x_q[C-1] && !cur_y_q[C-1]
		&& (CMP_BITS'(cur_x_q[POS_BITS-1:0]) < CMP_BITS'(width_q))
		&& (CMP_BITS'(cur_y_q[POS_BITS-1:0]) < CMP_BITS'(height_q));

	// Stage 1: pixel fields; an idle step carries zeros.
	logic signed [C-1:0]             px_s1;
	logic signed [C-1:0]             py_s1;
	logic [clr_pkg::COLOR_BITS-1:0]  color_s1;
	logic                            inside_s1;
	logic                            last_s1;
	logic                            idle_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= fire && is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_step) begin
			if (line_active_q) begin
				px_s1     <= cur_x_q;
				py_s1     <= cur_y_q;
				color_s1  <= color_q;
				inside_s1 <= on_screen;
				last_s1   <= at_end;
				idle_s1   <= 1'b0;
			end else begin
				px_s1     <= '0;
				py_s1     <= '0;
				color_s1  <= '0;
				inside_s1 <= 1'b0;
				last_s1   <= 1'b0;
				idle_s1   <= 1'b1;
			end
		end
	end

	// Stage 2: frame-buffer offset y * width + x.
	logic [PROD_BITS-1:0] prod;
	logic [SUM_BITS-1:0]  addr_sum;

	assign prod     = PROD_BITS'(py_s1[POS_BITS-1:0]) * PROD_BITS'(width_q);
	assign addr_sum = SUM_BITS'(prod) + SUM_BITS'(px_s1[POS_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel.pixel_x       <= px_s1;
			pixel.pixel_y       <= py_s1;
			pixel.pixel_address <= inside_s1 ? addr_sum[clr_pkg::ADDR_BITS-1:0] : '0;
			pixel.pixel_color   <= color_s1;
			pixel.write_enable  <= inside_s1;
			pixel.last_pixel    <= last_s1;
			pixel.line_idle     <= idle_s1;
		end
	end

	assign pixel.valid = valid_s2;

	// A written pixel has non-negative coordinates.
	a_we_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pixel.write_enable |-> !pixel.pixel_x[C-1] && !pixel.pixel_y[C-1])
		else $error("write enable on a pixel with a negative coordinate");

	// An idle beat neither writes nor ends a line.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pixel.line_idle |-> !pixel.write_enable && !pixel.last_pixel)
		else $error("idle beat carries a write or a last flag");

	// A step with no active line becomes an idle beat in stage 1.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_step && !line_active_q |=> valid_s1 && idle_s1)
		else $error("step without a line did not give an idle beat");

	// The endpoint pixel ends the line.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_step && line_active_q && at_end |=> !line_active_q)
		else $error("line still active after its endpoint");

	// A start always arms the engine.
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_step |=> line_active_q)
		else $error("start did not arm the line");

endmodule
`default_nettype wire

/* tb/sv/line_pixel_checker.sv */
`default_nettype none
// Watches the command and pixel channels and the register port, predicts
// every pixel beat of the line engine and compares each one as it arrives.
module line_pixel_checker #(
	parameter int COORD_BITS = 12
) (
	input  wire                                clk,
	input  wire                                arst_n,
	clr_cmd_if                                 cmd,
	clr_pixel_if                               pixel,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire                                pready,
	input  wire [clr_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire [clr_pkg::APB_DATA_BITS-1:0]   pwdata,
	output int                                 fail_count,
	output int                                 pending
);

	typedef struct packed {
		logic signed [COORD_BITS-1:0]       x;
		logic signed [COORD_BITS-1:0]       y;
		logic [clr_pkg::ADDR_BITS-1:0]      address;
		logic [clr_pkg::COLOR_BITS-1:0]     color;
		logic                               write_enable;
		logic                               last_pixel;
		logic                               line_idle;
	} pixel_beat_t;

	// Screen size as last written over the register port.
	logic [clr_pkg::DIM_BITS-1:0] scr_w, scr_h;

	// Walk state of the line being drawn.
	logic signed [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y;
	logic signed [COORD_BITS:0]   run_x, neg_run_y;
	logic signed [COORD_BITS+2:0] err;
	logic                         dir_x_neg, dir_y_neg, drawing;
	logic [clr_pkg::COLOR_BITS-1:0] color;

	// Pixel beats predicted but not yet seen, oldest first.
	pixel_beat_t pixel_q[$];

	// Applies one command to the walk state. Returns 1 when the command gives
	// a pixel beat, which is then left in beat.
	function automatic bit rasterize_command(input clr_pkg::opcode_t op,
			input logic signed [COORD_BITS-1:0] x0, y0, x1, y1,
			input logic [clr_pkg::COLOR_BITS-1:0] c, output pixel_beat_t beat);
		int span_x, span_y, twice;
		logic on_screen;
		beat = '0;
		if (op == clr_pkg::OP_START) begin
			span_x = int'(x1) - int'(x0);
			span_y = int'(y1) - int'(y0);
			if (span_x < 0) span_x = -span_x;
			if (span_y < 0) span_y = -span_y;
			cur_x = x0;
			cur_y = y0;
			end_x = x1;
			end_y = y1;
			run_x = (COORD_BITS+1)'(span_x);
			neg_run_y = (COORD_BITS+1)'(-span_y);
			dir_x_neg = !(x0 < x1);
			dir_y_neg = !(y0 < y1);
			err = (COORD_BITS+3)'(span_x - span_y);
			color = c;
			drawing = 1'b1;
			return 1'b0;
		end

		// A step with no line gives an idle beat with everything else zero.
		if (!drawing) begin
			beat.line_idle = 1'b1;
			return 1'b1;
		end

		on_screen = cur_x >= 0 && int'(cur_x) < int'(scr_w) &&
			cur_y >= 0 && int'(cur_y) < int'(scr_h);
		beat.x = cur_x;
		beat.y = cur_y;
		if (on_screen)
			beat.address = clr_pkg::ADDR_BITS'(int'(cur_y) * int'(scr_w) + int'(cur_x));
		beat.color = color;
		beat.write_enable = on_screen;
		beat.last_pixel = (cur_x == end_x) && (cur_y == end_y);

		// The endpoint closes the line; otherwise take one Bresenham step.
		if (beat.last_pixel) begin
			drawing = 1'b0;
		end else begin
			twice = 2 * int'(err);
			if (twice >= int'(neg_run_y)) begin
				err = err + neg_run_y;
				cur_x = dir_x_neg ? COORD_BITS'(cur_x - 1) : COORD_BITS'(cur_x + 1);
			end
			if (twice <= int'(run_x)) begin
				err = err + run_x;
				cur_y = dir_y_neg ? COORD_BITS'(cur_y - 1) : COORD_BITS'(cur_y + 1);
			end
		end
		return 1'b1;
	endfunction

	function automatic int field_mismatch(string name,
			logic [clr_pkg::ADDR_BITS-1:0] want, logic [clr_pkg::ADDR_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_beat_t beat, want, got;
		int bad;
		if (!arst_n) begin
			scr_w = clr_pkg::RESET_WIDTH;
			scr_h = clr_pkg::RESET_HEIGHT;
			cur_x = '0;
			cur_y = '0;
			end_x = '0;
			end_y = '0;
			run_x = '0;
			neg_run_y = '0;
			err = '0;
			dir_x_neg = 1'b0;
			dir_y_neg = 1'b0;
			color = '0;
			drawing = 1'b0;
			pixel_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			bad = 0;

			// Register writes land in the access cycle.
			if (psel && penable && pwrite && pready) begin
				case (clr_pkg::reg_index_t'(paddr[2]))
					clr_pkg::REG_WIDTH:  scr_w = pwdata[clr_pkg::DIM_BITS-1:0];
					clr_pkg::REG_HEIGHT: scr_h = pwdata[clr_pkg::DIM_BITS-1:0];
					default: ;
				endcase
			end

			if (cmd.valid && cmd.ready) begin
				if (rasterize_command(clr_pkg::opcode_t'(cmd.opcode), cmd.x_start,
						cmd.y_start, cmd.x_end, cmd.y_end, cmd.line_color, beat))
					pixel_q.push_back(beat);
			end

			// Each pixel beat is held against the oldest prediction.
			if (pixel.valid && pixel.ready) begin
				got.x = pixel.pixel_x;
				got.y = pixel.pixel_y;
				got.address = pixel.pixel_address;
				got.color = pixel.pixel_color;
				got.write_enable = pixel.write_enable;
				got.last_pixel = pixel.last_pixel;
				got.line_idle = pixel.line_idle;
				if (pixel_q.size() == 0) begin
					$display("%0t: pixel beat with no step waiting for it", $time);
					bad++;
				end else begin
					want = pixel_q.pop_front();
					bad += field_mismatch("pixel_x", clr_pkg::ADDR_BITS'(want.x),
						clr_pkg::ADDR_BITS'(got.x));
					bad += field_mismatch("pixel_y", clr_pkg::ADDR_BITS'(want.y),
						clr_pkg::ADDR_BITS'(got.y));
					bad += field_mismatch("pixel_address", want.address, got.address);
					bad += field_mismatch("pixel_color", clr_pkg::ADDR_BITS'(want.color),
						clr_pkg::ADDR_BITS'(got.color));
					bad += field_mismatch("write_enable",
						clr_pkg::ADDR_BITS'(want.write_enable),
						clr_pkg::ADDR_BITS'(got.write_enable));
					bad += field_mismatch("last_pixel", clr_pkg::ADDR_BITS'(want.last_pixel),
						clr_pkg::ADDR_BITS'(got.last_pixel));
					bad += field_mismatch("line_idle", clr_pkg::ADDR_BITS'(want.line_idle),
						clr_pkg::ADDR_BITS'(got.line_idle));
				end
			end

			fail_count <= fail_count + bad;
			pending <= pixel_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/sv/clipped_line_rasterizer_tb.sv */
`default_nettype none
module clipped_line_rasterizer_tb;

	localparam int COORD_BITS  = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 9;

	logic                              clk;
	logic                              arst_n;
	logic                              psel, penable, pwrite, pready;
	logic [clr_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [clr_pkg::APB_DATA_BITS-1:0] pwdata, prdata;

	int fail_count, pending, stuck_cycles, items_sent;
	int scr_w, scr_h;
	bit calm_tx, calm_rx, hold_rx;

	// Screen sizes visited after the reset size; a negative entry is drawn at random.
	int plan_w [PHASES] = '{1, 0, 53, 2047, 1024, 1024, 320, -1, -1};
	int plan_h [PHASES] = '{1, 37, 0, 2047, 1024, 1, 200, -1, -1};

	clr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
	clr_pixel_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

	clipped_line_rasterizer #(.COORD_BITS(COORD_BITS)) uut (
		.clk,
		.arst_n,
		.cmd(cmd_bus),
		.pixel(pix_bus),
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	line_pixel_checker #(.COORD_BITS(COORD_BITS)) pixel_check (
		.clk,
		.arst_n,
		.cmd(cmd_bus),
		.pixel(pix_bus),
		.psel,
		.penable,
		.pwrite,
		.pready,
		.paddr,
		.pwdata,
		.fail_count,
		.pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Offers one command beat after a random gap and waits until it is taken.
	task automatic send_cmd(clr_pkg::opcode_t op, int x0, int y0, int x1, int y1, int c);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.opcode <= op;
		cmd_bus.x_start <= COORD_BITS'(x0);
		cmd_bus.y_start <= COORD_BITS'(y0);
		cmd_bus.x_end <= COORD_BITS'(x1);
		cmd_bus.y_end <= COORD_BITS'(y1);
		cmd_bus.line_color <= clr_pkg::COLOR_BITS'(c);
		do @(posedge clk); while (!cmd_bus.ready);
		items_sent++;
	endtask

	// Step beats carry junk in the endpoint fields, which the block ignores.
	task automatic send_step();
		send_cmd(clr_pkg::OP_STEP, rand_between(-2048, 2047), rand_between(-2048, 2047),
			rand_between(-2048, 2047), rand_between(-2048, 2047), rand_between(0, 65535));
	endtask

	// Stops offering commands and waits for every predicted pixel beat.
	task automatic drain(int settle);
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(clr_pkg::reg_index_t idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {21'($urandom()), clr_pkg::DIM_BITS'(value)};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_screen(int w, int h);
		write_reg(clr_pkg::REG_WIDTH, w);
		write_reg(clr_pkg::REG_HEIGHT, h);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	// Mostly short lines near the screen drawn to their end, with some cut
	// short by a new start, some overrun into idle steps, some far-flung
	// starts and some lone steps.
	task automatic run_traffic(int quota);
		int stop_at, kind, x0, y0, x1, y1, ax, ay, reach, len;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0) calm_tx = !calm_tx;
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
				x0 = rand_between(-32, (scr_w > 1960) ? 1960 : scr_w + 16);
				y0 = rand_between(-32, (scr_h > 1960) ? 1960 : scr_h + 16);
				x1 = x0 + rand_between(-reach, reach);
				y1 = y0 + rand_between(-reach, reach);
				ax = (x1 > x0) ? x1 - x0 : x0 - x1;
				ay = (y1 > y0) ? y1 - y0 : y0 - y1;
				len = ((ax > ay) ? ax : ay) + 1;
				case ($urandom_range(0, 9))
					0: len = rand_between(1, len);
					1: len = len + rand_between(1, 3);
					default: ;
				endcase
				send_cmd(clr_pkg::OP_START, x0, y0, x1, y1, rand_between(0, 65535));
				repeat (len) send_step();
			end else if (kind < 90) begin
				send_cmd(clr_pkg::OP_START, rand_between(-2048, 2047),
					rand_between(-2048, 2047), rand_between(-2048, 2047),
					rand_between(-2048, 2047), rand_between(0, 65535));
				repeat ($urandom_range(0, 4)) send_step();
			end else begin
				repeat ($urandom_range(1, 3)) send_step();
			end
		end
	endtask

	// Pixel side: random stalls, calm stretches, and one long hold-off on request.
	initial begin : pixel_sink
		int stall;
		bit held;
		held = 1'b0;
		pix_bus.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_rx && !held) begin
				held = 1'b1;
				pix_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
			stall = calm_rx ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				pix_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_bus.ready <= 1'b1;
			do @(posedge clk); while (!(pix_bus.valid && pix_bus.ready));
		end
	end

	// Ends the run when no beat or register access moves for too long.
	always @(posedge clk) begin
		if (!arst_n || psel || (cmd_bus.valid && cmd_bus.ready) ||
				(pix_bus.valid && pix_bus.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.opcode <= clr_pkg::OP_START;
		cmd_bus.x_start <= '0;
		cmd_bus.y_start <= '0;
		cmd_bus.x_end <= '0;
		cmd_bus.y_end <= '0;
		cmd_bus.line_color <= '0;
		items_sent = 0;
		scr_w = 240;
		scr_h = 160;
		calm_tx = 1'b0;
		hold_rx = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines on the reset screen.
		send_step();
		send_cmd(clr_pkg::OP_START, 5, 5, 5, 5, 16'hFFFF);
		send_step();
		send_step();
		send_cmd(clr_pkg::OP_START, -2048, -2048, 2047, 2047, 0);
		send_step();
		send_step();
		// A new start drops the diagonal; this one crosses the far screen corner.
		send_cmd(clr_pkg::OP_START, 238, 158, 241, 161, 16'hA5A5);
		repeat (4) send_step();
		send_cmd(clr_pkg::OP_START, 3, 10, 0, 2, 16'h5A5A);
		repeat (9) send_step();
		send_step();
		run_traffic(150);

		// One phase per screen size, each written only once the block is idle.
		for (int i = 0; i < PHASES; i++) begin
			drain(4);
			set_screen((plan_w[i] < 0) ? rand_between(0, 2047) : plan_w[i],
				(plan_h[i] < 0) ? rand_between(0, 2047) : plan_h[i]);
			if (i == 4) begin
				calm_tx = 1'b1;
				hold_rx = 1'b1;
			end
			run_traffic(155);
		end

		drain(8);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/clr_pkg.sv
rtl/clr_ifs.sv
rtl/clipped_line_rasterizer.sv
tb/sv/line_pixel_checker.sv
tb/sv/clipped_line_rasterizer_tb.sv
